// ===== rtl/core/hgip_pkg.sv =====
package hgip_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int MAX_REPORTS = 16;

  localparam int WORD_W = 32;
  localparam int SLOT_W = 4;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_REPORTS + 1);
  localparam int IDX_W  = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;

  localparam int IN_W  = 72;
  localparam int OUT_W = 328;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PAGE_ZERO  = 3'd1,
    ST_SIZE_ZERO  = 3'd2,
    ST_ID_ZERO    = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_UNDERFLOW  = 3'd5,
    ST_TABLE_FULL = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    TAG_PAGE     = 4'd0,
    TAG_LOG_MIN  = 4'd1,
    TAG_LOG_MAX  = 4'd2,
    TAG_PHY_MIN  = 4'd3,
    TAG_PHY_MAX  = 4'd4,
    TAG_EXPONENT = 4'd5,
    TAG_UNIT     = 4'd6,
    TAG_SIZE     = 4'd7,
    TAG_REPORT   = 4'd8,
    TAG_COUNT    = 4'd9,
    TAG_PUSH     = 4'd10,
    TAG_POP      = 4'd11
  } tag_t;

  typedef struct packed {
    logic [WORD_W-1:0] usage_page;
    logic [WORD_W-1:0] logical_min;
    logic [WORD_W-1:0] logical_max;
    logic [WORD_W-1:0] physical_min;
    logic [WORD_W-1:0] physical_max;
    logic [WORD_W-1:0] unit_exponent;
    logic [WORD_W-1:0] unit_code;
    logic [WORD_W-1:0] field_size;
    logic [WORD_W-1:0] field_count;
    logic [WORD_W-1:0] report_id;
    logic [SLOT_W-1:0] report_slot;
  } glob_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic search;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_search;
    logic hit;
    logic miss;
  } sts_t;

endpackage

// ===== rtl/core/hid_global_item_processor_core.sv =====
// hid global item processor
// s_axis takes one decoded global item: a tag and its data, zero-extended
// and sign-extended. m_axis returns one result per item: a status and the
// full set of current globals after the item took effect.
// an item goes through accept, execute and an output load.
// a report id item with a nonzero id first walks the id table one entry
// per cycle through the table's single read port, up to the first match
// or through every stored id, of at most 16 in a full table.
// one item is in work at a time; s_axis_tready is high only while idle.
// a finished result sits in the output register; the next item is taken
// meanwhile and its result waits until m_axis_tready frees that register.
// reset clears the globals, the stack level and the table fill count;
// stack and table contents are not cleared and are never read unwritten.
module hid_global_item_processor_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // func [3:0], unsigned_value [35:4], signed_value [67:36], zero [71:68]
  input  logic [hgip_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status [2:0], usage_page_out [34:3], logical_min_out [66:35],
  // logical_max_out [98:67], physical_min_out [130:99],
  // physical_max_out [162:131], exponent_out [194:163], unit_out [226:195],
  // field_size_out [258:227], field_count_out [290:259],
  // report_id_out [322:291], report_slot_out [326:323], zero [327]
  output logic [hgip_pkg::OUT_W-1:0] m_axis_tdata
);

  hgip_pkg::cmd_t cmd;
  hgip_pkg::sts_t sts;

  hgip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hgip_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule

// ===== rtl/core/hgip_ctrl.sv =====
module hgip_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hgip_pkg::sts_t sts,
  output hgip_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.search   = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_search ? S_SEARCH : S_DONE;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.hit || sts.miss) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/hgip_datapath.sv =====
module hgip_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  hgip_pkg::cmd_t                cmd,
  output hgip_pkg::sts_t                sts,
  input  logic [hgip_pkg::IN_W-1:0]     in_data,
  output logic [hgip_pkg::OUT_W-1:0]    out_data
);

  hgip_pkg::tag_t              tag;
  logic [hgip_pkg::WORD_W-1:0] uval;
  logic [hgip_pkg::WORD_W-1:0] sval;

  hgip_pkg::glob_t             cur;
  hgip_pkg::status_t           st;
  logic [hgip_pkg::LVL_W-1:0]  level;
  logic [hgip_pkg::LVL_W-1:0]  level_m1;
  logic [hgip_pkg::CNT_W-1:0]  used;

  hgip_pkg::glob_t             stack_mem [hgip_pkg::STACK_DEPTH];
  hgip_pkg::glob_t             stack_rd;
  logic [hgip_pkg::WORD_W-1:0] id_table [hgip_pkg::MAX_REPORTS];
  logic [hgip_pkg::WORD_W-1:0] table_rd;

  logic [hgip_pkg::CNT_W-1:0]  idx;
  logic [hgip_pkg::CNT_W-1:0]  rd_idx;
  logic                        rd_vld;

  logic uval_zero;
  logic level_full;
  logic level_empty;
  logic table_full;
  logic do_push;
  logic do_append;
  logic issue;
  logic match;

  assign uval_zero   = (uval == '0);
  assign level_full  = (level == hgip_pkg::LVL_W'(hgip_pkg::STACK_DEPTH));
  assign level_empty = (level == '0);
  assign level_m1    = level - hgip_pkg::LVL_W'(1);
  assign table_full  = (used == hgip_pkg::CNT_W'(hgip_pkg::MAX_REPORTS));

  assign match     = rd_vld && (table_rd == uval);
  assign issue     = cmd.search && (idx != used);
  assign do_push   = cmd.exec && (tag == hgip_pkg::TAG_PUSH) && !level_full;
  assign do_append = cmd.search && sts.miss && !table_full;

  assign sts.need_search = (tag == hgip_pkg::TAG_REPORT) && !uval_zero;
  assign sts.hit         = match;
  assign sts.miss        = !match && (idx == used);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tag  <= hgip_pkg::tag_t'(in_data[3:0]);
      uval <= in_data[35:4];
      sval <= in_data[67:36];
    end
  end

  // stack of saved globals, top entry read back every cycle
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[level[hgip_pkg::SP_W-1:0]] <= cur;
    end
    stack_rd <= stack_mem[level_m1[hgip_pkg::SP_W-1:0]];
  end

  // report id table, one entry read per cycle during the search
  always_ff @(posedge clk) begin
    if (do_append) begin
      id_table[used[hgip_pkg::IDX_W-1:0]] <= uval;
    end
    table_rd <= id_table[idx[hgip_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_idx <= idx;
      if (issue) begin
        idx <= idx + hgip_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= '0;
      level <= '0;
      used  <= '0;
      st    <= hgip_pkg::ST_OK;
    end else if (cmd.exec) begin
      st <= hgip_pkg::ST_OK;
      unique case (tag)
        hgip_pkg::TAG_PAGE: begin
          if (uval_zero) begin
            st <= hgip_pkg::ST_PAGE_ZERO;
          end else begin
            cur.usage_page <= uval;
          end
        end
        hgip_pkg::TAG_LOG_MIN:  cur.logical_min   <= sval;
        hgip_pkg::TAG_LOG_MAX:  cur.logical_max   <= sval;
        hgip_pkg::TAG_PHY_MIN:  cur.physical_min  <= sval;
        hgip_pkg::TAG_PHY_MAX:  cur.physical_max  <= sval;
        hgip_pkg::TAG_EXPONENT: cur.unit_exponent <= sval;
        hgip_pkg::TAG_UNIT:     cur.unit_code     <= uval;
        hgip_pkg::TAG_SIZE: begin
          cur.field_size <= uval;
          if (uval_zero) begin
            st <= hgip_pkg::ST_SIZE_ZERO;
          end
        end
        hgip_pkg::TAG_REPORT: begin
          if (uval_zero) begin
            st <= hgip_pkg::ST_ID_ZERO;
          end
        end
        hgip_pkg::TAG_COUNT: cur.field_count <= uval;
        hgip_pkg::TAG_PUSH: begin
          if (level_full) begin
            st <= hgip_pkg::ST_OVERFLOW;
          end else begin
            level <= level + hgip_pkg::LVL_W'(1);
          end
        end
        hgip_pkg::TAG_POP: begin
          if (level_empty) begin
            st <= hgip_pkg::ST_UNDERFLOW;
          end else begin
            level <= level_m1;
            cur   <= stack_rd;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.search) begin
      if (sts.hit) begin
        cur.report_id   <= uval;
        cur.report_slot <= hgip_pkg::SLOT_W'(rd_idx);
      end else if (sts.miss) begin
        if (table_full) begin
          st <= hgip_pkg::ST_TABLE_FULL;
        end else begin
          cur.report_id   <= uval;
          cur.report_slot <= hgip_pkg::SLOT_W'(used);
          used            <= used + hgip_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {1'b0, cur.report_slot, cur.report_id, cur.field_count,
                   cur.field_size, cur.unit_code, cur.unit_exponent,
                   cur.physical_max, cur.physical_min, cur.logical_max,
                   cur.logical_min, cur.usage_page, st};
    end
  end

endmodule
